/* rtl/sct_pkg.sv */
package sct_pkg;

    localparam int unsigned DataW = 16;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ENTER  = 3'd1;
    localparam logic [2:0] OP_EXIT   = 3'd2;
    localparam logic [2:0] OP_WMODE  = 3'd3;
    localparam logic [2:0] OP_WCOUNT = 3'd4;

    localparam logic [1:0] SYNC_PAUSE_IN  = 2'd0;
    localparam logic [1:0] SYNC_RESET     = 2'd1;
    localparam logic [1:0] SYNC_RUN_IN    = 2'd2;
    localparam logic [1:0] SYNC_STOP      = 2'd3;

    // mode word bit positions
    localparam int unsigned MB_SYNC_EN  = 0;
    localparam int unsigned MB_SYNC_LO  = 1;
    localparam int unsigned MB_RST_TGT  = 3;
    localparam int unsigned MB_IRQ_TGT  = 4;
    localparam int unsigned MB_IRQ_END  = 5;
    localparam int unsigned MB_REPEAT   = 6;
    localparam int unsigned MB_TOGGLE   = 7;
    localparam int unsigned MB_SRC      = 8;
    localparam int unsigned MB_IRQ_REQ  = 10;
    localparam int unsigned MB_TGT_HIT  = 11;
    localparam int unsigned MB_END_HIT  = 12;
    localparam int unsigned MB_BLANK    = 15;

    localparam logic [2:0] APB_ADDR_TARGET = 3'd0;

    typedef enum logic [2:0] {
        K_NOP,
        K_TICK,
        K_ENTER,
        K_EXIT,
        K_WMODE,
        K_WCOUNT
    } t_kind;

    typedef struct packed {
        logic [2:0]       op;
        logic             source;
        logic [DataW-1:0] amount;
        logic [DataW-1:0] wdata;
    } t_in_req;

    typedef struct packed {
        logic [DataW-1:0] count;
        logic [DataW-1:0] mode_word;
        logic             irq;
    } t_out_req;

    typedef struct packed {
        t_kind            kind;
        logic             source;
        logic [DataW-1:0] amount;
        logic [DataW-1:0] wdata;
    } t_cmd;

endpackage

/* rtl/sct_front.sv */
module sct_front
    import sct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in_req i_in_req,
    output logic    o_cmd_valid,
    input  logic    i_cmd_ready,
    output t_cmd    o_cmd
);

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  n_valid;

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.source = i_in_req.source;
        n_cmd.amount = i_in_req.amount;
        n_cmd.wdata  = i_in_req.wdata;
        unique case (i_in_req.op)
            OP_TICK:   n_cmd.kind = K_TICK;
            OP_ENTER:  n_cmd.kind = K_ENTER;
            OP_EXIT:   n_cmd.kind = K_EXIT;
            OP_WMODE:  n_cmd.kind = K_WMODE;
            OP_WCOUNT: n_cmd.kind = K_WCOUNT;
            default:   n_cmd.kind = K_NOP;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* rtl/sct_queue.sv */
module sct_queue
    import sct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       r_mem [2];
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

/* rtl/sct_back.sv */
module sct_back
    import sct_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DataW-1:0] i_target,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  t_cmd             i_cmd,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_req         o_out_req
);

    logic [DataW-1:0] r_counter;
    logic [DataW-1:0] r_mode;
    logic             r_out_valid;
    t_out_req         r_out;

    logic [DataW-1:0] n_counter;
    logic [DataW-1:0] n_mode;
    logic             n_irq;

    logic             take;
    logic [1:0]       sync_sel;
    logic             sync_block;
    logic             allowed;
    logic [DataW:0]   sum;
    logic             hit_tgt;
    logic             tgt_flag;
    logic             end_flag;
    logic             intr;
    logic [DataW-1:0] tick_count;
    logic [DataW-1:0] tick_mode;
    logic             tick_irq;

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    assign sync_sel = r_mode[MB_SYNC_LO +: 2];

    always_comb begin
        unique case (sync_sel)
            SYNC_PAUSE_IN: sync_block = r_mode[MB_BLANK];
            SYNC_RESET:    sync_block = 1'b0;
            SYNC_RUN_IN:   sync_block = !r_mode[MB_BLANK];
            SYNC_STOP:     sync_block = 1'b1;
            default:       sync_block = 1'b0;
        endcase
    end

    assign allowed  = (r_mode[MB_SRC] == i_cmd.source)
                      && !(r_mode[MB_SYNC_EN] && sync_block);
    assign sum      = {1'b0, r_counter} + {1'b0, i_cmd.amount};
    assign hit_tgt  = ({1'b0, i_target} <= sum);
    assign tgt_flag = r_mode[MB_TGT_HIT] || hit_tgt;
    assign end_flag = r_mode[MB_END_HIT] || sum[DataW];
    assign intr     = (tgt_flag && r_mode[MB_IRQ_TGT]) || (end_flag && r_mode[MB_IRQ_END]);

    always_comb begin
        if (r_mode[MB_RST_TGT] && hit_tgt) begin
            tick_count = sum[DataW-1:0] - i_target;
        end else begin
            tick_count = sum[DataW-1:0];
        end
    end

    always_comb begin
        tick_mode = r_mode;
        tick_irq  = 1'b0;
        priority if (!r_mode[MB_REPEAT]) begin
            if (intr && r_mode[MB_IRQ_REQ]) begin
                tick_irq              = !r_mode[MB_TOGGLE];
                tick_mode[MB_IRQ_REQ] = 1'b0;
            end
        end else if (!r_mode[MB_TOGGLE]) begin
            tick_irq              = intr;
            tick_mode[MB_IRQ_REQ] = !intr;
        end else if (intr) begin
            tick_mode[MB_IRQ_REQ] = !r_mode[MB_IRQ_REQ];
            tick_irq              = !r_mode[MB_IRQ_REQ];
        end
        tick_mode[MB_TGT_HIT] = tgt_flag;
        tick_mode[MB_END_HIT] = end_flag;
    end

    always_comb begin
        n_counter = r_counter;
        n_mode    = r_mode;
        n_irq     = 1'b0;
        unique case (i_cmd.kind)
            K_TICK: begin
                if (allowed) begin
                    n_counter = tick_count;
                    n_mode    = tick_mode;
                    n_irq     = tick_irq;
                end
            end
            K_ENTER: begin
                n_mode[MB_BLANK] = 1'b1;
                if (r_mode[MB_SYNC_EN]) begin
                    if (sync_sel == SYNC_RESET || sync_sel == SYNC_RUN_IN) begin
                        n_counter = '0;
                    end else if (sync_sel == SYNC_STOP) begin
                        n_mode[MB_SYNC_EN] = 1'b0;
                    end
                end
            end
            K_EXIT: begin
                n_mode[MB_BLANK] = 1'b0;
            end
            K_WMODE: begin
                n_mode             = i_cmd.wdata;
                n_mode[MB_IRQ_REQ] = 1'b1;
                n_counter          = '0;
            end
            K_WCOUNT: begin
                n_counter = i_cmd.wdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_mode      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_counter   <= n_counter;
                r_mode      <= n_mode;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.count     <= n_counter;
            r_out.mode_word <= n_mode;
            r_out.irq       <= n_irq;
        end
    end

`ifndef NO_ASSERTIONS
    a_irq_clears_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.irq && !r_out.mode_word[MB_TOGGLE])
        |-> !r_out.mode_word[MB_IRQ_REQ])
        else $error("pulse irq left request bit set");

    a_toggle_irq_sets_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.irq && r_out.mode_word[MB_TOGGLE])
        |-> r_out.mode_word[MB_IRQ_REQ])
        else $error("toggle irq without request bit");

    a_state_mirrors_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.count == r_counter && r_out.mode_word == r_mode))
        else $error("output does not match counter state");
`endif

endmodule

/* rtl/sync_counter_timer.sv */
// channel  | valid      | ready       | payload
// in       | i_in_valid | o_in_ready  | i_in_req  (op, source, amount, wdata)
// out      | o_out_valid| i_out_ready | o_out_req (count, mode_word, irq)
// apb      | psel/penable | pready=1  | paddr, pwdata, prdata (target)
// One request per cycle sustained while the output is not stalled; a request passes
// the decode register, queue and result register. The 17-bit add and target compare sit in the back stage.
// Synchronous active-low reset clears count, mode word, target and all valids.
// A stalled output holds the back stage; the two-entry queue and decode
// register absorb requests until the input side stalls.
module sync_counter_timer
    import sct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out_req,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DataW-1:0] r_target;
    logic             f_valid;
    logic             f_ready;
    t_cmd             f_cmd;
    logic             q_valid;
    logic             q_ready;
    t_cmd             q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == APB_ADDR_TARGET) ? {16'h0000, r_target} : 32'h0000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (psel && penable && pwrite && pready && paddr == APB_ADDR_TARGET) begin
            r_target <= pwdata[DataW-1:0];
        end
    end

    sct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    sct_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    sct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_target    (r_target),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule
